// File: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the ring correction send scheduler: the
// per-node table entry, the result of one scheduling try and register codes.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int NODE_W   = 6;
  localparam int DIST_W   = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RING_NODES     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_OVER_ROOT = 8'd1;

  // Reset values of the configuration registers
  localparam logic [DIST_W-1:0] RING_NODES_RESET = 7'd64;
  localparam logic              WRAP_RESET       = 1'b1;

  // Smallest usable ring
  localparam logic [DIST_W-1:0] RING_MIN = 7'd2;

  // Nearest-sender value meaning nobody heard yet
  localparam logic [DIST_W-1:0] NEAREST_NONE = 7'h7f;

  // Event kinds and directions
  localparam logic KIND_POST    = 1'b0;
  localparam logic KIND_RECV    = 1'b1;
  localparam logic TRAVEL_LEFT  = 1'b0;
  localparam logic TRAVEL_RIGHT = 1'b1;
  localparam logic SIDE_LEFT    = 1'b0;
  localparam logic SIDE_RIGHT   = 1'b1;

  // One table entry: offsets and nearest-sender distances of both sides
  typedef struct packed {
    logic [DIST_W-1:0] left_offset;
    logic [DIST_W-1:0] left_nearest;
    logic [DIST_W-1:0] right_offset;
    logic [DIST_W-1:0] right_nearest;
  } rsc_entry_t;

  localparam rsc_entry_t ENTRY_RESET = '{
    left_offset:   '0,
    left_nearest:  NEAREST_NONE,
    right_offset:  '0,
    right_nearest: NEAREST_NONE
  };

  // Outcome of one scheduling try on an entry
  typedef struct packed {
    logic              done;
    logic              send;
    logic              dir;
    logic [NODE_W-1:0] recv;
    logic              retry;
    rsc_entry_t        entry;
  } rsc_try_t;

endpackage

// File: rtl/rsc_table.sv
// ----------------------------------------------------------------------------
// rsc_table
// Per-node state memory: one synchronous read port with registered data, one
// write port, and a valid bit per entry so that reset restores every entry.
// ----------------------------------------------------------------------------
module rsc_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output rsc_pkg::rsc_entry_t rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  rsc_pkg::rsc_entry_t wr_data
);

  rsc_pkg::rsc_entry_t mem [DEPTH];
  logic [DEPTH-1:0]    vld;
  rsc_pkg::rsc_entry_t rd_raw;
  logic                rd_vld;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Track written entries; reset drops them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  // An entry never written reads as its reset value
  assign rd_data = rd_vld ? rd_raw : rsc_pkg::ENTRY_RESET;

endmodule

// File: rtl/rsc_step.sv
// ----------------------------------------------------------------------------
// rsc_step
// One scheduling try on a table entry: done test, direction choice, offset
// advance, receiver and root crossing; or the nearest-sender update of a
// received message.
// ----------------------------------------------------------------------------
module rsc_step (
  input  logic                          kind,
  input  logic [rsc_pkg::NODE_W-1:0]    node,
  input  logic [rsc_pkg::NODE_W-1:0]    sender,
  input  logic                          msg_travel,
  input  logic [rsc_pkg::DIST_W-1:0]    ring,
  input  logic                          wrap,
  input  rsc_pkg::rsc_entry_t           cur,
  output rsc_pkg::rsc_try_t             res
);

  logic                       in_ring;
  logic                       l_open;
  logic                       r_open;
  logic [7:0]                 ring8;
  logic [7:0]                 off_sum;
  logic                       fin;
  logic                       dir;
  logic [rsc_pkg::DIST_W-1:0] lo1;
  logic [rsc_pkg::DIST_W-1:0] ro1;
  logic [7:0]                 left_raw;
  logic [7:0]                 right_raw;
  logic [7:0]                 left_red;
  logic [7:0]                 right_red;
  logic [rsc_pkg::DIST_W-1:0] recv7;
  logic                       crosses;
  logic [7:0]                 gap_raw;
  logic [7:0]                 gap_red;
  logic [rsc_pkg::DIST_W-1:0] gap;

  assign ring8   = {1'b0, ring};
  assign in_ring = ({2'b0, node} < ring8) &&
                   ((kind == rsc_pkg::KIND_POST) || ({2'b0, sender} < ring8));

  // Done test and direction choice
  assign l_open  = cur.left_offset < cur.left_nearest;
  assign r_open  = cur.right_offset < cur.right_nearest;
  assign off_sum = {1'b0, cur.left_offset} + {1'b0, cur.right_offset};
  assign fin     = (!l_open && !r_open) || (off_sum >= ring8);
  assign dir     = (l_open && r_open) ?
                   ((cur.left_offset < cur.right_offset) ? rsc_pkg::SIDE_LEFT
                                                         : rsc_pkg::SIDE_RIGHT) :
                   (l_open ? rsc_pkg::SIDE_LEFT : rsc_pkg::SIDE_RIGHT);

  // Advance offsets and reduce the receiver modulo the ring
  assign lo1       = cur.left_offset + 7'd1;
  assign ro1       = cur.right_offset + 7'd1;
  assign left_raw  = {2'b0, node} + ring8 - {1'b0, lo1};
  assign right_raw = {2'b0, node} + {1'b0, ro1};
  assign left_red  = (left_raw >= ring8) ? left_raw - ring8 : left_raw;
  assign right_red = (right_raw >= ring8) ? right_raw - ring8 : right_raw;
  assign recv7     = (dir == rsc_pkg::SIDE_LEFT) ? left_red[6:0] : right_red[6:0];
  assign crosses   = !wrap &&
                     (((dir == rsc_pkg::SIDE_LEFT) && (recv7 == ring - 7'd1)) ||
                      ((dir == rsc_pkg::SIDE_RIGHT) && (recv7 == 7'd0)));

  // Distance to the sender of a received message
  assign gap_raw = (msg_travel == rsc_pkg::TRAVEL_RIGHT) ?
                   ({2'b0, node} + ring8 - {2'b0, sender}) :
                   ({2'b0, sender} + ring8 - {2'b0, node});
  assign gap_red = (gap_raw >= ring8) ? gap_raw - ring8 : gap_raw;
  assign gap     = gap_red[6:0];

  always_comb begin
    res       = '0;
    res.entry = cur;
    if (!in_ring) begin
      res.entry = cur;
    end else if (kind == rsc_pkg::KIND_RECV) begin
      // Keep the nearest sender on the side the message came from
      if (msg_travel == rsc_pkg::TRAVEL_RIGHT) begin
        if (gap < cur.left_nearest) begin
          res.entry.left_nearest = gap;
        end
      end else begin
        if (gap < cur.right_nearest) begin
          res.entry.right_nearest = gap;
        end
      end
    end else if (fin) begin
      res.done = 1'b1;
    end else begin
      if (dir == rsc_pkg::SIDE_LEFT) begin
        res.entry.left_offset = lo1;
        if (crosses) begin
          res.entry.left_nearest = 7'd1;
        end
      end else begin
        res.entry.right_offset = ro1;
        if (crosses) begin
          res.entry.right_nearest = 7'd1;
        end
      end
      res.retry = crosses;
      res.send  = !crosses;
      res.dir   = crosses ? 1'b0 : dir;
      res.recv  = crosses ? '0 : recv7[5:0];
    end
  end

endmodule

// File: rtl/ring_correction_send_scheduler_core.sv
// ----------------------------------------------------------------------------
// ring_correction_send_scheduler_core
// Correction send scheduler for a ring: per-node table of sent offsets and
// nearest-sender distances, updated by post and receive events.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (in_valid/in_ready) with kind, node,
//   sender and msg_travel. Every event gives exactly one result item on the
//   output channel (out_valid/out_ready): phase_done, send_valid, send_side
//   and receiver. A receive event answers with all fields zero.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
//   the ring size (index 0) and the wrap-over-root switch (index 1); it is
//   always ready. It must be written only while no event is in flight; the
//   block itself does not enforce this. The event is taken, the table read is
//   registered in the load state, the scheduling step makes one try per cycle
//   with one more try for each turn back at node 0 (at most two), and the
//   write-back state presents the result. One event is handled at a time; the
//   next is taken the cycle after the result is registered.
//   Reset clears the table through per-entry valid bits at once, so events
//   are taken from the first cycle after reset. A stalled receiver holds the
//   result in the output register; one further event is taken and waits in
//   the write-back state until the output register frees.
// ----------------------------------------------------------------------------
module ring_correction_send_scheduler_core #(
  parameter int MAX_NODES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Event channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [rsc_pkg::NODE_W-1:0]       node,
  input  logic [rsc_pkg::NODE_W-1:0]       sender,
  input  logic                             msg_travel,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             phase_done,
  output logic                             send_valid,
  output logic                             send_side,
  output logic [rsc_pkg::NODE_W-1:0]       receiver
);

  localparam int NODE_SPAN = 1 << rsc_pkg::NODE_W;
  localparam int DEPTH     = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
  localparam int AW        = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_WB
  } state_t;

  state_t                          state;
  logic [rsc_pkg::DIST_W-1:0]      ring_nodes;
  logic                            wrap_over_root;
  logic [rsc_pkg::DIST_W-1:0]      ring;
  logic                            item_kind;
  logic [rsc_pkg::NODE_W-1:0]      item_node;
  logic [rsc_pkg::NODE_W-1:0]      item_sender;
  logic                            item_travel;
  rsc_pkg::rsc_entry_t             work;
  logic [1:0]                      tries;
  logic                            res_done;
  logic                            res_send;
  logic                            res_dir;
  logic [rsc_pkg::NODE_W-1:0]      res_recv;
  logic                            in_take;
  logic                            out_free;
  logic                            tbl_we;
  rsc_pkg::rsc_entry_t             tbl_q;
  rsc_pkg::rsc_try_t               step;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign tbl_we    = (state == S_WB) && out_free;

  // Clamp the ring size into the usable range
  always_comb begin
    if (ring_nodes < rsc_pkg::RING_MIN) begin
      ring = rsc_pkg::RING_MIN;
    end else if (32'(ring_nodes) > 32'(MAX_NODES)) begin
      ring = 7'(MAX_NODES);
    end else begin
      ring = ring_nodes;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_nodes     <= rsc_pkg::RING_NODES_RESET;
      wrap_over_root <= rsc_pkg::WRAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsc_pkg::REG_RING_NODES:     ring_nodes     <= cfg_data;
        rsc_pkg::REG_WRAP_OVER_ROOT: wrap_over_root <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rsc_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_take),
    .rd_addr (node[AW-1:0]),
    .rd_data (tbl_q),
    .wr_en   (tbl_we),
    .wr_addr (item_node[AW-1:0]),
    .wr_data (work)
  );

  rsc_step u_step (
    .kind       (item_kind),
    .node       (item_node),
    .sender     (item_sender),
    .msg_travel (item_travel),
    .ring       (ring),
    .wrap       (wrap_over_root),
    .cur        (work),
    .res        (step)
  );

  // Sequencer: take, load, try, write back and present the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      tries     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            item_kind   <= kind;
            item_node   <= node;
            item_sender <= sender;
            item_travel <= msg_travel;
            state       <= S_LOAD;
          end
        end
        S_LOAD: begin
          work  <= tbl_q;
          tries <= '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          work <= step.entry;
          if (step.retry && (tries != 2'd2)) begin
            // Turned back at node 0: try the other side
            tries <= tries + 2'd1;
          end else begin
            res_done <= step.done || step.retry;
            res_send <= step.send;
            res_dir  <= step.dir;
            res_recv <= step.recv;
            state    <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            phase_done <= res_done;
            send_valid <= res_send;
            send_side  <= res_dir;
            receiver   <= res_recv;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
